/* sv/onewire_uart_transaction_sequencer_unit_assert.svh */
// ----------------------------------------------------------------------------
// One-wire UART sequencer assertion macros
// Shared property templates, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_UART_TRANSACTION_SEQUENCER_UNIT_ASSERT_SVH
`define ONEWIRE_UART_TRANSACTION_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication
`define OWUTS_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("owuts: same-cycle check failed");

// Next-cycle implication
`define OWUTS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("owuts: next-cycle check failed");

`endif

/* sv/owuts_pkg.sv */
// ----------------------------------------------------------------------------
// owuts_pkg
// Types and constants shared by the one-wire UART sequencer modules.
// ----------------------------------------------------------------------------
package owuts_pkg;

    // Input opcodes (carried on s_tuser)
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_ECHO  = 2'd2;

    // Result kinds (carried on m_tuser)
    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_BUSY  = 2'd3;

    // UART frame values
    localparam logic [7:0] FRAME_RESET = 8'hf0;
    localparam logic [7:0] FRAME_ZERO  = 8'h00;
    localparam logic [7:0] FRAME_ONE   = 8'hff;
    localparam logic [7:0] CMD_SKIP_ROM = 8'hcc;

    // Job queue
    localparam int QUEUE_DEPTH = 4;

    // Bus transaction phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RESET,
        PH_ROM,
        PH_FUNC,
        PH_PAYLOAD
    } phase_t;

    // Action a job asks the back end to carry out
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_BYTE,
        ACT_RESET,
        ACT_DONE,
        ACT_BUSY
    } act_t;

    // One job: optional read byte, then the action
    typedef struct packed {
        logic       has_read;
        act_t       act;
        logic       use_buf;
        logic       present;
        logic [7:0] rd_byte;
        logic [7:0] frame_val;
    } job_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // One result beat
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] frame_byte;
        logic       fast_baud;
        logic       bus_present;
        logic [7:0] data_byte;
        logic       last;
    } beat_t;

endpackage

/* sv/owuts_front.sv */
// ----------------------------------------------------------------------------
// owuts_front
// Accepts input beats, tracks the bus transaction and turns each beat into
// at most one job for the back end. Holds the transmit buffer.
// ----------------------------------------------------------------------------
module owuts_front #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic                direction,
    input  logic [7:0]          func_cmd,
    input  logic [6:0]          length,
    input  logic [5:0]          tx_index,
    input  logic [7:0]          tx_byte,
    input  logic [7:0]          echo_byte,
    output logic                job_valid,
    output owuts_pkg::job_t     job,
    input  logic                job_ready
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    owuts_pkg::phase_t phase_reg, phase_next;
    logic              read_mode_reg, read_mode_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic [6:0]        len_reg, len_next;
    logic [6:0]        pos_reg, pos_next;
    logic [2:0]        slot_reg, slot_next;
    logic [7:0]        acc_reg, acc_next;
    logic              pres_reg, pres_next;

    logic              pend_valid_reg, pend_valid_next;
    owuts_pkg::job_t   pend_job_reg, job_next;
    logic [7:0]        rd_data_reg;
    logic [7:0]        tx_mem [MAX_PAYLOAD];

    logic              in_fire;
    logic              has_res;
    logic              adv_payload;
    logic              buf_we;
    logic [7:0]        acc_upd;
    logic [AW-1:0]     rd_addr;

    assign in_ready  = !pend_valid_reg || job_ready;
    assign in_fire   = in_valid && in_ready;
    assign job_valid = pend_valid_reg;

    // Payload byte comes from the buffer read made at acceptance
    always_comb
    begin
        job = pend_job_reg;
        if (pend_job_reg.use_buf)
        begin
            job.frame_val = rd_data_reg;
        end
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= owuts_pkg::PH_IDLE;
            read_mode_reg  <= 1'b0;
            cmd_reg        <= 8'd0;
            len_reg        <= 7'd0;
            pos_reg        <= 7'd0;
            slot_reg       <= 3'd0;
            acc_reg        <= 8'd0;
            pres_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            read_mode_reg  <= read_mode_next;
            cmd_reg        <= cmd_next;
            len_reg        <= len_next;
            pos_reg        <= pos_next;
            slot_reg       <= slot_next;
            acc_reg        <= acc_next;
            pres_reg       <= pres_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Job payload register
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pend_job_reg <= job_next;
        end
    end

    // Transmit buffer: write on load, registered read on every accepted beat
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            tx_mem[AW'(tx_index)] <= tx_byte;
        end
        if (in_fire)
        begin
            rd_data_reg <= tx_mem[rd_addr];
        end
    end

    // Classify the beat and advance the transaction
    always_comb
    begin
        phase_next     = phase_reg;
        read_mode_next = read_mode_reg;
        cmd_next       = cmd_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        slot_next      = slot_reg;
        acc_next       = acc_reg;
        pres_next      = pres_reg;
        job_next       = '0;
        job_next.act   = owuts_pkg::ACT_NONE;
        has_res        = 1'b0;
        adv_payload    = 1'b0;
        buf_we         = 1'b0;
        rd_addr        = AW'(pos_reg);
        acc_upd        = acc_reg | ((echo_byte == owuts_pkg::FRAME_ONE) ?
                                    (8'd1 << slot_reg) : 8'd0);

        if (in_fire)
        begin
            unique case (opcode)
                owuts_pkg::OP_START:
                begin
                    has_res = 1'b1;
                    if (phase_reg != owuts_pkg::PH_IDLE)
                    begin
                        job_next.act = owuts_pkg::ACT_BUSY;
                    end
                    else
                    begin
                        read_mode_next = direction;
                        cmd_next       = func_cmd;
                        if (int'(length) > MAX_PAYLOAD)
                        begin
                            len_next = 7'(MAX_PAYLOAD);
                        end
                        else
                        begin
                            len_next = length;
                        end
                        pos_next     = 7'd0;
                        slot_next    = 3'd0;
                        acc_next     = 8'd0;
                        phase_next   = owuts_pkg::PH_RESET;
                        job_next.act = owuts_pkg::ACT_RESET;
                    end
                end
                owuts_pkg::OP_LOAD:
                begin
                    if (phase_reg == owuts_pkg::PH_IDLE && int'(tx_index) < MAX_PAYLOAD)
                    begin
                        buf_we = 1'b1;
                    end
                end
                owuts_pkg::OP_ECHO:
                begin
                    unique case (phase_reg)
                        owuts_pkg::PH_RESET:
                        begin
                            pres_next          = (echo_byte != owuts_pkg::FRAME_RESET);
                            slot_next          = 3'd0;
                            acc_next           = 8'd0;
                            phase_next         = owuts_pkg::PH_ROM;
                            has_res            = 1'b1;
                            job_next.act       = owuts_pkg::ACT_BYTE;
                            job_next.frame_val = owuts_pkg::CMD_SKIP_ROM;
                        end
                        owuts_pkg::PH_ROM, owuts_pkg::PH_FUNC, owuts_pkg::PH_PAYLOAD:
                        begin
                            if (slot_reg != 3'd7)
                            begin
                                slot_next = slot_reg + 3'd1;
                                acc_next  = acc_upd;
                            end
                            else
                            begin
                                slot_next = 3'd0;
                                acc_next  = 8'd0;
                                has_res   = 1'b1;
                                if (phase_reg == owuts_pkg::PH_ROM)
                                begin
                                    phase_next         = owuts_pkg::PH_FUNC;
                                    job_next.act       = owuts_pkg::ACT_BYTE;
                                    job_next.frame_val = cmd_reg;
                                end
                                else
                                begin
                                    adv_payload = 1'b1;
                                    if (phase_reg == owuts_pkg::PH_PAYLOAD)
                                    begin
                                        job_next.has_read = read_mode_reg;
                                        job_next.rd_byte  = acc_upd;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase

            // Next payload byte, or the end of the transaction
            if (adv_payload)
            begin
                if (pos_reg >= len_reg)
                begin
                    phase_next   = owuts_pkg::PH_IDLE;
                    job_next.act = owuts_pkg::ACT_DONE;
                end
                else
                begin
                    phase_next         = owuts_pkg::PH_PAYLOAD;
                    job_next.act       = owuts_pkg::ACT_BYTE;
                    job_next.use_buf   = !read_mode_reg;
                    job_next.frame_val = owuts_pkg::FRAME_ONE;
                    pos_next           = pos_reg + 7'd1;
                end
            end
        end

        job_next.present = pres_next;

        // Pending stage handshake
        if (in_fire)
        begin
            pend_valid_next = has_res;
        end
        else if (job_ready)
        begin
            pend_valid_next = 1'b0;
        end
        else
        begin
            pend_valid_next = pend_valid_reg;
        end
    end

endmodule

/* sv/owuts_queue.sv */
// ----------------------------------------------------------------------------
// owuts_queue
// Short job FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module owuts_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  owuts_pkg::job_t     push_job,
    input  logic                pop,
    output owuts_pkg::job_t     head,
    output owuts_pkg::q_stat_t  stat
);

    localparam int PW = $clog2(owuts_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(owuts_pkg::QUEUE_DEPTH + 1);

    owuts_pkg::job_t entries_reg [owuts_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign head       = entries_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CW'(owuts_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* sv/owuts_back.sv */
// ----------------------------------------------------------------------------
// owuts_back
// Takes jobs from the queue and serialises them into result beats, one per
// cycle while out_ready allows, through an output register.
// ----------------------------------------------------------------------------
module owuts_back (
    input  logic                clk,
    input  logic                rst_n,
    input  owuts_pkg::job_t     head,
    input  owuts_pkg::q_stat_t  stat,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output owuts_pkg::beat_t    out_beat
);

    logic              cur_valid_reg, cur_valid_next;
    owuts_pkg::job_t   cur_job_reg;
    logic              rd_pend_reg, rd_pend_next;
    logic [2:0]        bit_reg, bit_next;
    logic              out_valid_reg;
    owuts_pkg::beat_t  out_beat_reg;

    owuts_pkg::beat_t  beat;
    logic              out_load;
    logic              fire;
    logic              cur_done;

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;
    assign out_load  = !out_valid_reg || out_ready;
    assign fire      = cur_valid_reg && out_load;
    assign cur_done  = fire && beat.last;
    assign pop       = !stat.empty && (!cur_valid_reg || cur_done);

    // Beat for the current step of the job
    always_comb
    begin
        beat             = '0;
        beat.bus_present = cur_job_reg.present;
        if (rd_pend_reg)
        begin
            beat.kind      = owuts_pkg::KIND_READ;
            beat.data_byte = cur_job_reg.rd_byte;
            beat.last      = (cur_job_reg.act == owuts_pkg::ACT_NONE);
        end
        else
        begin
            unique case (cur_job_reg.act)
                owuts_pkg::ACT_BYTE:
                begin
                    beat.kind       = owuts_pkg::KIND_FRAME;
                    beat.frame_byte = cur_job_reg.frame_val[bit_reg] ?
                                      owuts_pkg::FRAME_ONE : owuts_pkg::FRAME_ZERO;
                    beat.fast_baud  = 1'b1;
                    beat.last       = (bit_reg == 3'd7);
                end
                owuts_pkg::ACT_RESET:
                begin
                    beat.kind       = owuts_pkg::KIND_FRAME;
                    beat.frame_byte = owuts_pkg::FRAME_RESET;
                    beat.last       = 1'b1;
                end
                owuts_pkg::ACT_DONE:
                begin
                    beat.kind = owuts_pkg::KIND_DONE;
                    beat.last = 1'b1;
                end
                owuts_pkg::ACT_BUSY:
                begin
                    beat.kind = owuts_pkg::KIND_BUSY;
                    beat.last = 1'b1;
                end
                default:
                begin
                    beat.last = 1'b1;
                end
            endcase
        end
    end

    // Step through the job
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        rd_pend_next   = rd_pend_reg;
        bit_next       = bit_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            rd_pend_next   = head.has_read;
            bit_next       = 3'd0;
        end
        else if (cur_done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (fire)
        begin
            if (rd_pend_reg)
            begin
                rd_pend_next = 1'b0;
            end
            else
            begin
                bit_next = bit_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            bit_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            rd_pend_reg   <= rd_pend_next;
            bit_reg       <= bit_next;
            if (out_load)
            begin
                out_valid_reg <= fire;
            end
        end
    end

    // Job and output payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_job_reg <= head;
        end
        if (out_load)
        begin
            out_beat_reg <= beat;
        end
    end

endmodule

/* sv/onewire_uart_transaction_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// onewire_uart_transaction_sequencer_unit: 1-Wire master over UART slots
// An input beat is taken every cycle while the job queue has room.
// A job passes the pending register, the queue, the current-job register and the output register.
// Results leave one per cycle while jobs are queued and m_tready is high; a finished byte gives up to 9 results.
// Reset clears control state; the transmit buffer keeps its contents.
// ----------------------------------------------------------------------------
`include "onewire_uart_transaction_sequencer_unit_assert.svh"

module onewire_uart_transaction_sequencer_unit #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // direction[0], func_cmd[8:1], length[15:9], tx_index[21:16],
    // tx_byte[29:22], echo_byte[37:30], zero fill[39:38]
    input  logic [39:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // frame_byte[7:0], fast_baud[8], bus_present[9], data_byte[17:10],
    // zero fill[23:18]
    output logic [23:0] m_tdata,
    // kind[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    logic                job_valid;
    owuts_pkg::job_t     job;
    logic                q_push;
    logic                q_pop;
    owuts_pkg::job_t     q_head;
    owuts_pkg::q_stat_t  q_stat;
    owuts_pkg::beat_t    beat;

    assign q_push = job_valid && !q_stat.full;

    // Front end: classify beats, hold the transaction state
    owuts_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .opcode    (s_tuser),
        .direction (s_tdata[0]),
        .func_cmd  (s_tdata[8:1]),
        .length    (s_tdata[15:9]),
        .tx_index  (s_tdata[21:16]),
        .tx_byte   (s_tdata[29:22]),
        .echo_byte (s_tdata[37:30]),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (!q_stat.full)
    );

    // Job queue
    owuts_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (job),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    // Back end: serialise jobs into result beats
    owuts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .stat      (q_stat),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (beat)
    );

    // Output packing
    assign m_tdata = {6'd0, beat.data_byte, beat.bus_present, beat.fast_baud,
                      beat.frame_byte};
    assign m_tuser = beat.kind;
    assign m_tlast = beat.last;

    // Checks
    `OWUTS_ASSERT_IMPL(a_pop_not_empty, q_pop, !q_stat.empty)
    `OWUTS_ASSERT_IMPL(a_push_not_full, q_push, !q_stat.full)
    `OWUTS_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_stat.empty)
    `OWUTS_ASSERT_IMPL(a_busy_is_last, m_tvalid && m_tuser == owuts_pkg::KIND_BUSY, m_tlast)

endmodule

/* verif/onewire_uart_transaction_sequencer_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// One-wire UART sequencer testbench
// Drives opcode beats into the sequencer and predicts every result beat from
// a local model of the bus transaction. The model covers the reset frame,
// skip-ROM, the function command, payload slots and rebuilt read bytes.
// Both stream sides idle at random, and the result side is held off once for
// a long stretch so that the input stalls. Each result is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module onewire_uart_transaction_sequencer_unit_tb;

    localparam int         MAX_PAYLOAD    = 64;
    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         RANDOM_BEATS   = 40;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 20;

    // One input beat, unpacked
    typedef struct packed {
        logic [1:0] opcode;
        logic       direction;
        logic [7:0] func_cmd;
        logic [6:0] length;
        logic [5:0] tx_index;
        logic [7:0] tx_byte;
        logic [7:0] echo_byte;
    } cmd_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Shadow of the sequencer state
    owuts_pkg::phase_t bus_phase    = owuts_pkg::PH_IDLE;
    logic              read_mode    = 1'b0;
    logic [7:0]        func_byte    = 8'h00;
    int                payload_len  = 0;
    int                payload_pos  = 0;
    logic [2:0]        slot_idx     = 3'd0;
    logic [7:0]        slot_bits    = 8'h00;
    logic              present_flag = 1'b0;
    logic [7:0]        tx_shadow [MAX_PAYLOAD];
    bit                tx_loaded [MAX_PAYLOAD];

    owuts_pkg::beat_t  pending_results [$];

    int         mismatch_count  = 0;
    int         effective_beats = 0;
    int         quiet_left      = 0;
    bit         no_gaps         = 1'b0;
    bit         hold_req        = 1'b0;
    bit         hold_active     = 1'b0;

    onewire_uart_transaction_sequencer_unit #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic void push_result(logic [1:0] kind, logic [7:0] frame, logic fast,
                                        logic [7:0] data);
        owuts_pkg::beat_t r;
        r.kind        = kind;
        r.frame_byte  = frame;
        r.fast_baud   = fast;
        r.bus_present = present_flag;
        r.data_byte   = data;
        r.last        = 1'b0;
        pending_results.push_back(r);
    endfunction

    // Eight fast-baud slot frames, LSB first
    function automatic void push_slot_frames(logic [7:0] value);
        for (int i = 0; i < 8; i++)
            push_result(owuts_pkg::KIND_FRAME,
                        value[i] ? owuts_pkg::FRAME_ONE : owuts_pkg::FRAME_ZERO,
                        1'b1, 8'h00);
    endfunction

    // Either the done beat or the slots of the next payload byte
    function automatic void next_payload_byte();
        if (payload_pos >= payload_len)
        begin
            bus_phase = owuts_pkg::PH_IDLE;
            push_result(owuts_pkg::KIND_DONE, 8'h00, 1'b0, 8'h00);
        end
        else
        begin
            // read slots are all ones
            push_slot_frames(read_mode ? owuts_pkg::FRAME_ONE : tx_shadow[payload_pos]);
            payload_pos++;
            bus_phase = owuts_pkg::PH_PAYLOAD;
        end
    endfunction

    // Queues the results of one accepted beat; returns 1 when it is ignored
    function automatic bit predict_bus_results(cmd_beat_t b);
        int         queued;
        bit         ignored;
        logic [7:0] got;
        queued  = pending_results.size();
        ignored = 1'b0;
        case (b.opcode)
            owuts_pkg::OP_START:
            begin
                if (bus_phase != owuts_pkg::PH_IDLE)
                    push_result(owuts_pkg::KIND_BUSY, 8'h00, 1'b0, 8'h00);
                else
                begin
                    read_mode   = b.direction;
                    func_byte   = b.func_cmd;
                    payload_len = (b.length > MAX_PAYLOAD) ? MAX_PAYLOAD : b.length;
                    payload_pos = 0;
                    slot_idx    = 3'd0;
                    slot_bits   = 8'h00;
                    bus_phase   = owuts_pkg::PH_RESET;
                    push_result(owuts_pkg::KIND_FRAME, owuts_pkg::FRAME_RESET, 1'b0, 8'h00);
                end
            end
            owuts_pkg::OP_LOAD:
            begin
                // a 6-bit index never reaches MAX_PAYLOAD
                if (bus_phase == owuts_pkg::PH_IDLE)
                begin
                    tx_shadow[b.tx_index] = b.tx_byte;
                    tx_loaded[b.tx_index] = 1'b1;
                end
                else
                    ignored = 1'b1;
            end
            owuts_pkg::OP_ECHO:
            begin
                if (bus_phase == owuts_pkg::PH_IDLE)
                    ignored = 1'b1;
                else if (bus_phase == owuts_pkg::PH_RESET)
                begin
                    present_flag = (b.echo_byte != owuts_pkg::FRAME_RESET);
                    slot_idx     = 3'd0;
                    slot_bits    = 8'h00;
                    bus_phase    = owuts_pkg::PH_ROM;
                    push_slot_frames(owuts_pkg::CMD_SKIP_ROM);
                end
                else
                begin
                    if (b.echo_byte == owuts_pkg::FRAME_ONE)
                        slot_bits[slot_idx] = 1'b1;
                    if (slot_idx != 3'd7)
                        slot_idx++;
                    else
                    begin
                        got       = slot_bits;
                        slot_idx  = 3'd0;
                        slot_bits = 8'h00;
                        if (bus_phase == owuts_pkg::PH_ROM)
                        begin
                            bus_phase = owuts_pkg::PH_FUNC;
                            push_slot_frames(func_byte);
                        end
                        else if (bus_phase == owuts_pkg::PH_FUNC)
                            next_payload_byte();
                        else
                        begin
                            if (read_mode)
                                push_result(owuts_pkg::KIND_READ, 8'h00, 1'b0, got);
                            next_payload_byte();
                        end
                    end
                end
            end
            default:
                ignored = 1'b1;
        endcase
        if (pending_results.size() > queued)
            pending_results[pending_results.size() - 1].last = 1'b1;
        return ignored;
    endfunction

    // ------------------------------------------------------------------------
    // Beat builders and random picks
    // ------------------------------------------------------------------------

    // Unused fields carry random junk
    function automatic cmd_beat_t junk_beat(logic [1:0] op);
        cmd_beat_t   b;
        logic [63:0] raw;
        raw      = {$urandom, $urandom};
        b        = raw[39:0];
        b.opcode = op;
        return b;
    endfunction

    function automatic cmd_beat_t start_beat(logic dir, logic [7:0] cmd, logic [6:0] len);
        cmd_beat_t b;
        b           = junk_beat(owuts_pkg::OP_START);
        b.direction = dir;
        b.func_cmd  = cmd;
        b.length    = len;
        return b;
    endfunction

    function automatic cmd_beat_t load_beat(logic [5:0] idx, logic [7:0] value);
        cmd_beat_t b;
        b          = junk_beat(owuts_pkg::OP_LOAD);
        b.tx_index = idx;
        b.tx_byte  = value;
        return b;
    endfunction

    function automatic cmd_beat_t echo_beat(logic [7:0] value);
        cmd_beat_t b;
        b           = junk_beat(owuts_pkg::OP_ECHO);
        b.echo_byte = value;
        return b;
    endfunction

    // Echo that fits the current phase, now and then a malformed one
    function automatic logic [7:0] slot_echo();
        int r;
        r = $urandom_range(0, 99);
        if (bus_phase == owuts_pkg::PH_RESET)
            return (r < 40) ? owuts_pkg::FRAME_RESET : 8'($urandom_range(0, 255));
        if (r < 45)
            return owuts_pkg::FRAME_ZERO;
        if (r < 90)
            return owuts_pkg::FRAME_ONE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Number of buffer entries loaded from index 0 upwards without a hole
    function automatic int loaded_run();
        int n;
        n = 0;
        while (n < MAX_PAYLOAD && tx_loaded[n])
            n++;
        return n;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_send_gap();
        if (no_gaps)
            return 0;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            quiet_left = $urandom_range(10, 30);
            return 0;
        end
        return pick_gap();
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offers one beat, predicts on acceptance, then maybe idles
    task automatic send_beat(cmd_beat_t b);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= b.opcode;
        s_tdata  <= {2'b00, b.echo_byte, b.tx_byte, b.tx_index, b.length, b.func_cmd,
                     b.direction};
        do
            @(posedge clk);
        while (!s_tready);
        if (!predict_bus_results(b))
            effective_beats++;
        gap = pick_send_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic pause_sender();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Answers slots until the transaction is over, optionally with stray beats
    task automatic finish_transaction(bit with_noise);
        int r;
        while (bus_phase != owuts_pkg::PH_IDLE)
        begin
            r = $urandom_range(0, 99);
            if (with_noise && r < 3)
                send_beat(start_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                     7'($urandom_range(0, 127))));
            else if (with_noise && r < 6)
                send_beat(load_beat(6'($urandom_range(0, 63)), 8'($urandom_range(0, 255))));
            else if (with_noise && r < 8)
                send_beat(junk_beat(OP_UNUSED));
            else
                send_beat(echo_beat(slot_echo()));
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        int burst;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_active = 1'b1;
                m_tready   <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req    = 1'b0;
                hold_active = 1'b0;
            end
            else if ($urandom_range(0, 99) < 65)
            begin
                burst     = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 6);
                m_tready <= 1'b1;
                repeat (burst) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat (1 + pick_gap()) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        owuts_pkg::beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing pending: kind %0d, tdata 0x%0h",
                       m_tuser, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", 8'(want.kind), 8'(m_tuser));
                check_field("frame_byte", want.frame_byte, m_tdata[7:0]);
                check_field("fast_baud", 8'(want.fast_baud), 8'(m_tdata[8]));
                check_field("bus_present", 8'(want.bus_present), 8'(m_tdata[9]));
                check_field("data_byte", want.data_byte, m_tdata[17:10]);
                check_field("last", 8'(want.last), 8'(m_tlast));
            end
        end
    end

    // Watchdog: too long without any beat on either side
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Buffer loads at both ends of the index range and byte range
    task automatic test_buffer_loads();
        send_beat(load_beat(6'd0, 8'h00));
        send_beat(load_beat(6'd1, 8'hff));
        send_beat(load_beat(6'd2, 8'ha5));
        send_beat(load_beat(6'd3, 8'h5a));
        send_beat(load_beat(6'd63, 8'h81));
    endtask

    // Echo while idle and an unknown opcode: no result
    task automatic test_idle_noise();
        send_beat(echo_beat(owuts_pkg::FRAME_ONE));
        send_beat(echo_beat(owuts_pkg::FRAME_RESET));
        send_beat(junk_beat(OP_UNUSED));
    endtask

    // Write of the loaded bytes, device present
    task automatic test_write_transaction();
        send_beat(start_beat(1'b0, 8'h3c, 7'd2));
        send_beat(echo_beat(8'he0));
        finish_transaction(1'b0);
    endtask

    // Read with no device: bytes of all ones, all zeros and mixed slots
    task automatic test_read_transaction();
        send_beat(start_beat(1'b1, 8'hff, 7'd3));
        send_beat(echo_beat(owuts_pkg::FRAME_RESET));
        repeat (16) send_beat(echo_beat(slot_echo()));
        repeat (8) send_beat(echo_beat(owuts_pkg::FRAME_ONE));
        repeat (8) send_beat(echo_beat(owuts_pkg::FRAME_ZERO));
        // anything but all ones reads as a zero bit
        for (int i = 0; i < 8; i++)
            send_beat(echo_beat((i % 2 == 1) ? 8'hfe : owuts_pkg::FRAME_ONE));
        finish_transaction(1'b0);
    endtask

    // Zero length: done straight after the function command
    task automatic test_zero_length();
        send_beat(start_beat(1'b0, 8'h00, 7'd0));
        send_beat(echo_beat(8'h00));
        finish_transaction(1'b0);
    endtask

    // Start and load while a transaction runs
    task automatic test_busy_cases();
        send_beat(start_beat(1'b0, 8'h81, 7'd1));
        send_beat(start_beat(1'b1, 8'h12, 7'd5));
        send_beat(echo_beat(8'h10));
        send_beat(load_beat(6'd0, 8'h77));
        send_beat(start_beat(1'b0, 8'hee, 7'd0));
        finish_transaction(1'b0);
    endtask

    // Largest length field; the run stops two bytes into the payload
    task automatic test_oversize_length();
        send_beat(start_beat(1'b1, 8'ha5, 7'd127));
        send_beat(echo_beat(slot_echo()));
        repeat (32) send_beat(echo_beat(slot_echo()));
        send_beat(start_beat(1'b0, 8'h11, 7'd1));
    endtask

    // Long hold-off on the result side while input beats keep coming
    task automatic test_backpressure();
        pause_sender();
        hold_req = 1'b1;
        wait (hold_active);
        no_gaps = 1'b1;
        send_beat(start_beat(1'b1, 8'h5a, 7'd3));
        finish_transaction(1'b0);
        no_gaps = 1'b0;
    endtask

    // Mostly well-formed transactions with random content, stray beats mixed in
    task automatic test_random_traffic();
        int   target;
        int   len;
        int   loads;
        int   idx;
        logic dir;
        target = effective_beats + RANDOM_BEATS;
        while (effective_beats < target)
        begin
            // loads mostly extend the run of written entries
            loads = $urandom_range(0, 3);
            for (int i = 0; i < loads; i++)
            begin
                idx = (loaded_run() < MAX_PAYLOAD && $urandom_range(0, 3) != 0)
                      ? loaded_run() : $urandom_range(0, 63);
                send_beat(load_beat(6'(idx), 8'($urandom_range(0, 255))));
            end
            if ($urandom_range(0, 9) == 0)
                send_beat($urandom_range(0, 1) ? echo_beat(8'($urandom_range(0, 255)))
                                               : junk_beat(OP_UNUSED));
            // writes never reach an entry that was never loaded
            dir = 1'($urandom_range(0, 1));
            len = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            if (!dir && len > loaded_run())
                len = loaded_run();
            send_beat(start_beat(dir, 8'($urandom_range(0, 255)), 7'(len)));
            finish_transaction(1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_buffer_loads();
        test_idle_noise();
        test_write_transaction();
        test_read_transaction();
        test_zero_length();
        test_busy_cases();
        test_backpressure();
        test_random_traffic();
        test_oversize_length();

        // let every predicted beat arrive, then watch for strays
        pause_sender();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
